FILE: hdl/pobb_pkg.sv
`default_nettype none
package pobb_pkg;
   localparam int unsigned CoordW = 24;
   localparam int unsigned PadW = 23;
   localparam int unsigned DiffW = 25;
   localparam int unsigned AccW = 53;
   localparam int unsigned LimW = 27;
   localparam int unsigned WordsPerBox = 18;

   typedef enum logic [1:0] {
      CSR_PADDING = 2'd0,
      CSR_ACTIVE  = 2'd1
   } csr_index_type;

   typedef enum logic [0:0] {
      KIND_LOAD  = 1'b0,
      KIND_POINT = 1'b1
   } kind_type;

   typedef struct packed {
      logic signed [CoordW-1:0] x;
      logic signed [CoordW-1:0] y;
      logic signed [CoordW-1:0] z;
      logic [PadW-1:0]          extra;
   } point_type;

   typedef struct packed {
      logic              valid;
      logic              near;
      point_type         pt;
   } token_type;

   typedef struct packed {
      logic              we;
      logic [4:0]        word;
      logic [CoordW-1:0] value;
   } load_type;
endpackage
`default_nettype wire

FILE: hdl/pobb_cell.sv
`default_nettype none
module pobb_cell
   import pobb_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          advance,
   input  wire logic          enable,
   input  wire logic [PadW-1:0] padding,
   input  wire load_type      load,
   input  wire token_type     tok_in,
   output token_type          tok_out
);
   // box words
   logic signed [CoordW-1:0] word_ff [WordsPerBox];

   // stage 1: differences, thresholds
   token_type s1_ff, s1_in;
   logic signed [DiffW-1:0] d_ff [3];
   logic signed [LimW-1:0]  lim_ff [3];
   logic signed [CoordW-1:0] c_ff [3];
   // stage 2: products
   token_type s2_ff;
   logic signed [AccW-1:0] prod_ff [9];
   logic signed [LimW-1:0]  lim2_ff [3];
   logic signed [CoordW-1:0] c2_ff [3];
   // stage 3: compare
   token_type s3_ff, s3_in;

   logic signed [CoordW-1:0] pc [3];
   logic signed [AccW-1:0] acc [3];
   logic signed [AccW-1:0] mg [3];
   logic ok;

   always_ff @(posedge clock) begin
      if (load.we) word_ff[load.word] <= load.value;
   end

   assign pc[0] = tok_in.pt.x;
   assign pc[1] = tok_in.pt.y;
   assign pc[2] = tok_in.pt.z;
   assign s1_in = tok_in;

   always_comb begin
      ok = 1'b1;
      for (int i = 0; i < 3; i++) begin
         acc[i] = prod_ff[i] + prod_ff[3+i] + prod_ff[6+i]
                  - (AccW'(c2_ff[i]) <<< 16);
         mg[i] = acc[i][AccW-1] ? -acc[i] : acc[i];
         if (mg[i] > (AccW'(lim2_ff[i]) <<< 16)) ok = 1'b0;
      end
      s3_in = s2_ff;
      if (s2_ff.valid && enable && ok) s3_in.near = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_ff <= s1_in;
         s2_ff <= s1_ff;
         s3_ff <= s3_in;
         for (int j = 0; j < 3; j++) begin
            d_ff[j] <= DiffW'(pc[j]) - DiffW'(word_ff[9+j]);
            lim_ff[j] <= LimW'(word_ff[15+j]) + LimW'({1'b0, padding})
                         + LimW'({1'b0, tok_in.pt.extra});
            c_ff[j] <= word_ff[12+j];
         end
         for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
               prod_ff[j*3+i] <= AccW'(word_ff[j*3+i]) * AccW'(d_ff[j]);
            end
            lim2_ff[j] <= lim_ff[j];
            c2_ff[j] <= c_ff[j];
         end
      end
   end

   assign tok_out = s3_ff;
endmodule
`default_nettype wire

FILE: hdl/point_obb_proximity_mask_core.sv
`default_nettype none
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_stall  | kind, box_index, word_index, word_value, point, extra
// rsp     | out       | rsp_valid/rsp_stall  | hit, out_x/y/z
// csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
// a point transaction can enter every cycle while the chain advances; each box cell
// adds its s1, s2 and s3 stage registers, and the output register follows the last cell
// a load transaction waits until no point is left in the cell chain (output stalls
// can prolong the wait), so no point sees a box word written after it
// the whole chain advances together; it halts while the output register is
// full and stalled
// reset clears valid bits, the csr registers and the in-flight count; box words are undefined until loaded
module point_obb_proximity_mask_core
   import pobb_pkg::*;
#(
   parameter int unsigned BOXES = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_kind,
   input  wire logic [3:0]         req_box_index,
   input  wire logic [4:0]         req_word_index,
   input  wire logic signed [23:0] req_word_value,
   input  wire logic signed [23:0] req_point_x,
   input  wire logic signed [23:0] req_point_y,
   input  wire logic signed [23:0] req_point_z,
   input  wire logic [22:0]        req_extra_padding,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_hit,
   output logic signed [23:0]      rsp_out_x,
   output logic signed [23:0]      rsp_out_y,
   output logic signed [23:0]      rsp_out_z,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [23:0]        csr_data
);
   localparam int unsigned FlightW = $clog2(3 * BOXES + 1);

   logic [PadW-1:0]    padding_ff;
   logic [4:0]         active_ff;
   token_type          chain [BOXES+1];
   token_type          out_ff;
   logic               advance;
   logic               req_fire;
   logic [FlightW-1:0] flight_ff, flight_in;
   logic               load_wait;

   // chain moves unless the output register holds a stalled result
   assign advance = !(out_ff.valid && rsp_stall);
   // loads hold off while points are still inside the cells
   assign load_wait = (req_kind == KIND_LOAD) && (flight_ff != '0);
   assign req_stall = !advance || load_wait;
   assign req_fire = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         padding_ff <= '0;
         active_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PADDING: padding_ff <= csr_data[PadW-1:0];
            CSR_ACTIVE:  active_ff <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   // points held in the cell stages
   always_comb begin
      flight_in = flight_ff;
      if (advance) begin
         if (chain[0].valid && !chain[BOXES].valid) flight_in = flight_ff + 1'b1;
         else if (!chain[0].valid && chain[BOXES].valid) flight_in = flight_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) flight_ff <= '0;
      else flight_ff <= flight_in;
   end

   // point entry token
   always_comb begin
      chain[0].valid = req_fire && (req_kind == KIND_POINT);
      chain[0].near = 1'b0;
      chain[0].pt.x = req_point_x;
      chain[0].pt.y = req_point_y;
      chain[0].pt.z = req_point_z;
      chain[0].pt.extra = req_extra_padding;
   end

   for (genvar b = 0; b < BOXES; b++) begin : g_cell
      load_type ld;
      logic     en;
      always_comb begin
         ld.we = req_fire && (req_kind == KIND_LOAD) && (32'(req_box_index) == b)
                 && (req_word_index < 5'(WordsPerBox));
         ld.word = req_word_index;
         ld.value = req_word_value;
         en = 32'(active_ff) > b;
      end
      pobb_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .enable  (en),
         .padding (padding_ff),
         .load    (ld),
         .tok_in  (chain[b]),
         .tok_out (chain[b+1])
      );
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) out_ff.valid <= 1'b0;
      else if (advance) out_ff <= chain[BOXES];
   end

   assign rsp_valid = out_ff.valid;
   assign rsp_hit = out_ff.near;
   assign rsp_out_x = out_ff.pt.x;
   assign rsp_out_y = out_ff.pt.y;
   assign rsp_out_z = out_ff.pt.z;

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit))
      else $error("result changed under stall");
   // no new transaction taken while output is blocked
   a_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while output blocked");
   // with no active boxes nothing is near
   a_none: assert property (@(posedge clock) disable iff (reset)
      active_ff == 5'd0 && $past(active_ff) == 5'd0 && chain[0].valid |-> !chain[1].near)
      else $error("near flag set with no boxes");
endmodule
`default_nettype wire
